// ===== rtl/graph_adjacency_degree_tracker_assert.svh =====
// Assertion macros for the checker file of the degree tracker.
`ifndef GRAPH_ADJACENCY_DEGREE_TRACKER_ASSERT_SVH
`define GRAPH_ADJACENCY_DEGREE_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GDT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("degree tracker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GDT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("degree tracker assertion failed");

`endif

// ===== rtl/gdt_pkg.sv =====
package gdt_pkg;

  // Built graph size and the widths that follow from it.
  localparam int MAX_NODES = 16;
  localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int DEG_W     = IDX_W;

  // Fixed field widths of the item and result.
  localparam int NODE_W      = 4;
  localparam int CFG_W       = 5;
  localparam int MASK_W      = 16;
  localparam int DEG_OUT_W   = 4;
  localparam int DEG_OUT_MAX = 15;
  localparam int NC_W        = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int CMP_W       = (NC_W > NODE_W) ? NC_W : NODE_W;

  // Configuration port.
  localparam int REG_W     = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = '0;
  localparam logic [CFG_W-1:0]     NODE_COUNT_RST = CFG_W'(16);

  // Item kinds and result status codes.
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_ADDED     = 2'd0,
    ST_INVALID   = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_REPORT    = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic update;
    logic step;
    logic load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic sweep_last;
  } dp_stat_t;

endpackage

// ===== rtl/gdt_if.sv =====
// Input item channel: an edge insert or a report request.
interface gdt_in_if;
  import gdt_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source(output valid, kind, node_a, node_b, input ready);
  modport sink(input valid, kind, node_a, node_b, output ready);
endinterface

// Result item channel: status and graph statistics.
interface gdt_out_if;
  import gdt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [NODE_W-1:0]    busiest_node;
  logic [DEG_OUT_W-1:0] busiest_degree;
  logic [MASK_W-1:0]    isolated_mask;
  logic                 is_regular;

  modport source(output valid, status, busiest_node, busiest_degree, isolated_mask,
                 is_regular, input ready);
  modport sink(input valid, status, busiest_node, busiest_degree, isolated_mask,
               is_regular, output ready);
endinterface

// ===== rtl/gdt_cfg.sv =====
module gdt_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gdt_pkg::ADDR_W-1:0]  paddr,
  input  logic [gdt_pkg::REG_W-1:0]   pwdata,
  output logic [gdt_pkg::REG_W-1:0]   prdata,
  output logic                        pready,
  output logic [gdt_pkg::CFG_W-1:0]   node_count_o
);
  import gdt_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [CFG_W-1:0]     node_count_q;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // The node count register, written in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (wr_en && (reg_idx == REG_NODE_COUNT)) begin
      node_count_q <= pwdata[CFG_W-1:0];
    end
  end

  // Read decode.
  always_comb begin
    unique case (reg_idx)
      REG_NODE_COUNT: prdata = REG_W'(node_count_q);
      default:        prdata = '0;
    endcase
  end

  assign node_count_o = node_count_q;
endmodule

// ===== rtl/gdt_dp.sv =====
module gdt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gdt_pkg::dp_cmd_t              cmd_i,
  output gdt_pkg::dp_stat_t             stat_o,
  input  logic                          kind_i,
  input  logic [gdt_pkg::NODE_W-1:0]    node_a_i,
  input  logic [gdt_pkg::NODE_W-1:0]    node_b_i,
  input  logic [gdt_pkg::CFG_W-1:0]     node_count_i,
  output logic [1:0]                    status_o,
  output logic [gdt_pkg::NODE_W-1:0]    busiest_node_o,
  output logic [gdt_pkg::DEG_OUT_W-1:0] busiest_degree_o,
  output logic [gdt_pkg::MASK_W-1:0]    isolated_mask_o,
  output logic                          is_regular_o
);
  import gdt_pkg::*;

  // Graph state.
  logic [MAX_NODES-1:0] adj_q [MAX_NODES];
  logic [DEG_W-1:0]     deg_q [MAX_NODES];

  // Captured item.
  logic              kind_q;
  logic [NODE_W-1:0] a_q;
  logic [NODE_W-1:0] b_q;

  // Sweep accumulators.
  status_e           status_q;
  logic [CNT_W-1:0]  idx_q;
  logic [IDX_W-1:0]  best_q;
  logic [DEG_W-1:0]  best_deg_q;
  logic [MASK_W-1:0] mask_q;
  logic              regular_q;

  // Result register.
  logic [1:0]           res_status_q;
  logic [NODE_W-1:0]    res_node_q;
  logic [DEG_OUT_W-1:0] res_deg_q;
  logic [MASK_W-1:0]    res_mask_q;
  logic                 res_regular_q;

  logic [NC_W-1:0]   nc_ext;
  logic [NC_W-1:0]   nc_clip;
  logic [CNT_W-1:0]  n_act;
  logic [IDX_W-1:0]  a_idx;
  logic [IDX_W-1:0]  b_idx;
  logic              a_in;
  logic              b_in;
  status_e           status_d;
  logic              add_edge;
  logic [DEG_W-1:0]  cur_deg;
  logic [MASK_W-1:0] mask_hit;

  // Number of active nodes: the register limited to the built size.
  assign nc_ext  = NC_W'(node_count_i);
  assign nc_clip = (nc_ext < NC_W'(MAX_NODES)) ? nc_ext : NC_W'(MAX_NODES);
  assign n_act   = CNT_W'(nc_clip);

  // Endpoint checks and the duplicate lookup.
  assign a_idx = IDX_W'(a_q);
  assign b_idx = IDX_W'(b_q);
  assign a_in  = CMP_W'(a_q) < CMP_W'(n_act);
  assign b_in  = CMP_W'(b_q) < CMP_W'(n_act);

  always_comb begin
    if (kind_q == KIND_REPORT) begin
      status_d = ST_REPORT;
    end else if ((a_q == b_q) || !a_in || !b_in) begin
      status_d = ST_INVALID;
    end else if (adj_q[a_idx][b_idx]) begin
      status_d = ST_DUPLICATE;
    end else begin
      status_d = ST_ADDED;
    end
  end

  assign add_edge = cmd_i.update && (status_d == ST_ADDED);

  // Matrix bits and degree counters; each row updates in place.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_NODES; j++) begin
        adj_q[j] <= '0;
        deg_q[j] <= '0;
      end
    end else if (add_edge) begin
      for (int j = 0; j < MAX_NODES; j++) begin
        if (IDX_W'(j) == a_idx) begin
          adj_q[j][b_idx] <= 1'b1;
        end
        if (IDX_W'(j) == b_idx) begin
          adj_q[j][a_idx] <= 1'b1;
        end
        if ((IDX_W'(j) == a_idx) || (IDX_W'(j) == b_idx)) begin
          deg_q[j] <= deg_q[j] + DEG_W'(1);
        end
      end
    end
  end

  // Item capture on acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      a_q    <= node_a_i;
      b_q    <= node_b_i;
    end
  end

  // Degree of the node under the sweep pointer, and its isolated-mask bit.
  assign cur_deg = deg_q[idx_q[IDX_W-1:0]];

  always_comb begin
    for (int k = 0; k < MASK_W; k++) begin
      mask_hit[k] = (int'(idx_q) == k) && (cur_deg == '0);
    end
  end

  // Sweep over the active nodes, one per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      status_q   <= status_d;
      idx_q      <= '0;
      best_q     <= '0;
      best_deg_q <= '0;
      mask_q     <= '0;
      regular_q  <= 1'b1;
    end else if (cmd_i.step) begin
      if (cur_deg > best_deg_q) begin
        best_q     <= idx_q[IDX_W-1:0];
        best_deg_q <= cur_deg;
      end
      mask_q <= mask_q | mask_hit;
      if (cur_deg != deg_q[0]) begin
        regular_q <= 1'b0;
      end
      idx_q <= idx_q + CNT_W'(1);
    end
  end

  // Result register, loaded once the output slot is free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_status_q  <= status_q;
      res_node_q    <= NODE_W'(best_q);
      res_deg_q     <= (int'(best_deg_q) > DEG_OUT_MAX) ? DEG_OUT_W'(DEG_OUT_MAX)
                                                        : DEG_OUT_W'(best_deg_q);
      res_mask_q    <= mask_q;
      res_regular_q <= regular_q;
    end
  end

  assign stat_o.empty      = (n_act == '0);
  assign stat_o.sweep_last = (idx_q == (n_act - CNT_W'(1)));

  assign status_o         = res_status_q;
  assign busiest_node_o   = res_node_q;
  assign busiest_degree_o = res_deg_q;
  assign isolated_mask_o  = res_mask_q;
  assign is_regular_o     = res_regular_q;
endmodule

// ===== rtl/gdt_ctrl.sv =====
module gdt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gdt_pkg::dp_cmd_t  cmd_o,
  input  gdt_pkg::dp_stat_t stat_i
);
  import gdt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_SWEEP,
    S_DONE
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && in_ready_q;
  assign out_free = !out_valid_q || out_ready_i;

  // Datapath commands.
  assign cmd_o.capture = accept;
  assign cmd_o.update  = (state_q == S_UPDATE);
  assign cmd_o.step    = (state_q == S_SWEEP);
  assign cmd_o.load    = (state_q == S_DONE) && out_free;

  // Sequencer with the handshake flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      // A taken result clears the flag unless a new one is loaded in its place.
      if (out_valid_q && out_ready_i && !cmd_o.load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            in_ready_q <= 1'b0;
            state_q    <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state_q <= stat_i.empty ? S_DONE : S_SWEEP;
        end
        S_SWEEP: begin
          if (stat_i.sweep_last) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            in_ready_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;
endmodule

// ===== rtl/graph_adjacency_degree_tracker.sv =====
// Degree tracker for an undirected graph of up to MAX_NODES nodes, kept as a
// symmetric bit adjacency matrix and one degree counter per node in flip-flops
// that reset clears at once, so no clearing pass follows reset. Every item
// (edge insert or report) gives one result with its status, the lowest-index
// busiest active node and its degree, the isolated-node mask and a regularity
// flag. From acceptance to a valid result an item is checked and its edge
// inserted, the degree counters are swept, one active node per cycle
// (node_count limited to MAX_NODES), and the result register is loaded once
// the output slot is free. One item is worked on at a time, and the next is
// accepted as soon as the result is loaded, even while it still waits to be
// taken. Write node_count only while the block is idle.
module graph_adjacency_degree_tracker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  gdt_in_if.sink                     in_i,
  gdt_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gdt_pkg::ADDR_W-1:0] paddr,
  input  logic [gdt_pkg::REG_W-1:0]  pwdata,
  output logic [gdt_pkg::REG_W-1:0]  prdata,
  output logic                       pready
);
  import gdt_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [CFG_W-1:0] node_count;
  logic             in_ready;
  logic             out_valid;

  // Configuration register.
  gdt_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .node_count_o (node_count)
  );

  // Sequencer.
  gdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Matrix, counters and statistics sweep.
  gdt_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .kind_i           (in_i.kind),
    .node_a_i         (in_i.node_a),
    .node_b_i         (in_i.node_b),
    .node_count_i     (node_count),
    .status_o         (out_o.status),
    .busiest_node_o   (out_o.busiest_node),
    .busiest_degree_o (out_o.busiest_degree),
    .isolated_mask_o  (out_o.isolated_mask),
    .is_regular_o     (out_o.is_regular)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
endmodule

// ===== rtl/gdt_chk.sv =====
`include "graph_adjacency_degree_tracker_assert.svh"

module gdt_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [1:0]                    status_i,
  input logic [gdt_pkg::NODE_W-1:0]    busiest_node_i,
  input logic [gdt_pkg::DEG_OUT_W-1:0] busiest_degree_i,
  input logic [gdt_pkg::MASK_W-1:0]    isolated_mask_i,
  input logic                          is_regular_i
);
  import gdt_pkg::*;

  // One item at a time: acceptance closes the input until the result is loaded.
  `GDT_ASSERT_NXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // With every degree zero the busiest node stays the first one.
  `GDT_ASSERT_IMP(a_zero_busiest, clk_i, rst_ni, out_valid_i && (busiest_degree_i == '0), busiest_node_i == '0)

  // The busiest node is never reported isolated when it has edges.
  `GDT_ASSERT_IMP(a_busiest_linked, clk_i, rst_ni, out_valid_i && (busiest_degree_i != '0), !isolated_mask_i[busiest_node_i])

  // A regular graph with edges has no isolated node.
  `GDT_ASSERT_IMP(a_regular_mask, clk_i, rst_ni, out_valid_i && is_regular_i && (busiest_degree_i != '0), isolated_mask_i == '0)

  // A stalled result holds.
  `GDT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({status_i, busiest_node_i, busiest_degree_i, isolated_mask_i, is_regular_i}))
endmodule

bind graph_adjacency_degree_tracker gdt_chk u_gdt_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .busiest_node_i   (out_o.busiest_node),
  .busiest_degree_i (out_o.busiest_degree),
  .isolated_mask_i  (out_o.isolated_mask),
  .is_regular_i     (out_o.is_regular)
);

// ===== tb/graph_adjacency_degree_tracker_test.sv =====
`timescale 1ns / 1ps

module graph_adjacency_degree_tracker_test;
  import gdt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 37;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SHOW_MAX    = 10;

  // Statistics expected for one result item.
  typedef struct packed {
    status_e                status;
    logic [NODE_W-1:0]      busiest_node;
    logic [DEG_OUT_W-1:0]   busiest_degree;
    logic [MASK_W-1:0]      isolated_mask;
    logic                   is_regular;
  } graph_stats_t;

  // Mirror of the graph with the statistics it owes and the mismatch count.
  class degree_scoreboard;
    bit           links[MAX_NODES][MAX_NODES];
    int unsigned  degree[MAX_NODES];
    int unsigned  node_count;
    graph_stats_t stats_q[$];
    int unsigned  mismatches;

    function new();
      node_count = NODE_COUNT_RST;
      mismatches = 0;
      foreach (degree[i]) begin
        degree[i] = 0;
        foreach (links[i][j]) links[i][j] = 1'b0;
      end
    endfunction

    function void set_node_count(int unsigned value);
      node_count = value & 5'h1f;
    endfunction

    function int unsigned pending();
      return stats_q.size();
    endfunction

    function void fail(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= SHOW_MAX) begin
        $display("%0t: %s expected %0d, got %0d", $realtime, what, want, got);
      end
    endfunction

    // Apply an accepted item to the mirror and queue the statistics it yields.
    function void note_item(kind_e kind, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
      int unsigned  active;
      int unsigned  best_deg;
      graph_stats_t stats;
      active = (node_count < MAX_NODES) ? node_count : MAX_NODES;
      if (kind == KIND_REPORT) begin
        stats.status = ST_REPORT;
      end else if (a == b || a >= active || b >= active) begin
        stats.status = ST_INVALID;
      end else if (links[a][b]) begin
        stats.status = ST_DUPLICATE;
      end else begin
        links[a][b] = 1'b1;
        links[b][a] = 1'b1;
        degree[a]++;
        degree[b]++;
        stats.status = ST_ADDED;
      end

      // Sweep the active nodes for the busiest node, isolation and regularity.
      stats.busiest_node  = '0;
      stats.isolated_mask = '0;
      stats.is_regular    = 1'b1;
      best_deg = (active > 0) ? degree[0] : 0;
      for (int unsigned i = 0; i < active; i++) begin
        if (degree[i] > best_deg) begin
          best_deg = degree[i];
          stats.busiest_node = NODE_W'(i);
        end
        if (degree[i] == 0 && i < MASK_W) stats.isolated_mask[i] = 1'b1;
        if (degree[i] != degree[0]) stats.is_regular = 1'b0;
      end
      stats.busiest_degree = (best_deg > DEG_OUT_MAX) ? DEG_OUT_W'(DEG_OUT_MAX)
                                                      : DEG_OUT_W'(best_deg);
      stats_q.push_back(stats);
    endfunction

    // Compare one result item with the oldest queued statistics.
    function void check_result(logic [1:0] status, logic [NODE_W-1:0] node,
                               logic [DEG_OUT_W-1:0] deg, logic [MASK_W-1:0] mask,
                               logic regular);
      graph_stats_t want;
      if (stats_q.size() == 0) begin
        fail("unexpected result, status", 0, status);
        return;
      end
      want = stats_q.pop_front();
      if (want.status != status) fail("status", want.status, status);
      if (want.busiest_node != node) fail("busiest_node", want.busiest_node, node);
      if (want.busiest_degree != deg) fail("busiest_degree", want.busiest_degree, deg);
      if (want.isolated_mask != mask) fail("isolated_mask", want.isolated_mask, mask);
      if (want.is_regular != regular) fail("is_regular", want.is_regular, regular);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [REG_W-1:0]    pwdata;
  logic [REG_W-1:0]    prdata;
  logic                pready;
  logic                steady_send;
  logic                steady_recv;
  logic                recv_hold;
  int unsigned         cycles;
  degree_scoreboard    sb;

  gdt_in_if  in_ch();
  gdt_out_if out_ch();

  graph_adjacency_degree_tracker i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result items are checked before the item accepted in the same cycle is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.status, out_ch.busiest_node, out_ch.busiest_degree,
                        out_ch.isolated_mask, out_ch.is_regular);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_item(kind_e'(in_ch.kind), in_ch.node_a, in_ch.node_b);
      end
    end
  end

  // Receiver side: random stalls, a steady stretch, and a long hold-off.
  always @(negedge clk_i) begin
    if (recv_hold) begin
      out_ch.ready = 1'b0;
    end else if (steady_recv) begin
      out_ch.ready = 1'b1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one item, with random idle cycles first; returns at the falling edge
  // after acceptance.
  task automatic send_item(kind_e kind, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    while (!steady_send && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid  = 1'b1;
    in_ch.kind   = kind;
    in_ch.node_a = a;
    in_ch.node_b = b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One register access: setup cycle, then access cycle.
  task automatic reg_access(logic write, logic [REG_W-1:0] wdata,
                            output logic [REG_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = {REG_NODE_COUNT, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Change the node count once the block is idle, and read it back.
  task automatic set_node_count(int unsigned value);
    logic [REG_W-1:0] rdata;
    drain();
    reg_access(1'b1, REG_W'(value), rdata);
    sb.set_node_count(value);
    reg_access(1'b0, '0, rdata);
    if (rdata !== REG_W'(value & 5'h1f)) sb.fail("node_count readback", value, rdata);
  endtask

  // Mostly valid edges among the active nodes, some arbitrary inserts, some reports.
  task automatic send_random(int unsigned count);
    int unsigned      active;
    int unsigned      pick;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    active = (sb.node_count < MAX_NODES) ? sb.node_count : MAX_NODES;
    repeat (count) begin
      pick = $urandom_range(99);
      a = NODE_W'($urandom_range(15));
      b = NODE_W'($urandom_range(15));
      if (pick < 70 && active >= 2) begin
        a = NODE_W'($urandom_range(active - 1));
        do b = NODE_W'($urandom_range(active - 1)); while (b == a);
        send_item(KIND_INSERT, a, b);
      end else if (pick < 85 || active < 2) begin
        send_item(KIND_INSERT, a, b);
      end else begin
        send_item(KIND_REPORT, a, b);
      end
    end
  endtask

  initial begin
    sb          = new();
    cycles      = 0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    steady_send = 1'b0;
    steady_recv = 1'b0;
    recv_hold   = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_INSERT;
    in_ch.node_a = '0;
    in_ch.node_b = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty graph with all nodes active, then self loops.
    send_item(KIND_REPORT, 4'd0, 4'd0);
    send_item(KIND_INSERT, 4'd3, 4'd3);
    send_item(KIND_INSERT, 4'd15, 4'd15);

    // Two nodes: one edge makes a regular graph; duplicates and out-of-range ends.
    set_node_count(2);
    send_item(KIND_INSERT, 4'd0, 4'd1);
    send_item(KIND_INSERT, 4'd1, 4'd0);
    send_item(KIND_INSERT, 4'd0, 4'd2);
    send_item(KIND_INSERT, 4'd15, 4'd0);

    // A single node is regular; no active nodes rejects every insert.
    set_node_count(1);
    send_item(KIND_REPORT, 4'd9, 4'd6);
    send_item(KIND_INSERT, 4'd0, 4'd1);
    set_node_count(0);
    send_item(KIND_REPORT, 4'd0, 4'd0);
    send_item(KIND_INSERT, 4'd0, 4'd1);
    send_item(KIND_REPORT, 4'd15, 4'd15);

    // Count above the built maximum is limited to it.
    set_node_count(31);
    send_item(KIND_INSERT, 4'd15, 4'd14);
    send_item(KIND_INSERT, 4'd0, 4'd15);
    send_item(KIND_REPORT, 4'd5, 4'd10);
    set_node_count(16);
    send_item(KIND_INSERT, 4'd14, 4'd15);

    // Shrunk count: the edge to node 15 still counts in the degree of node 0.
    set_node_count(3);
    send_item(KIND_REPORT, 4'd0, 4'd0);
    send_item(KIND_INSERT, 4'd2, 4'd1);

    // Random phases over several node counts.
    set_node_count(4);
    send_random(40);
    set_node_count(16);
    steady_send = 1'b1;
    steady_recv = 1'b1;
    send_random(90);
    steady_send = 1'b0;
    steady_recv = 1'b0;
    set_node_count(7);
    send_random(60);
    set_node_count(31);
    send_random(60);
    set_node_count(12);
    send_random(60);
    set_node_count(16);
    fork
      begin
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        recv_hold = 1'b0;
      end
    join_none
    send_random(90);

    drain();
    repeat (MAX_NODES + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gdt_pkg.sv
rtl/gdt_if.sv
rtl/gdt_cfg.sv
rtl/gdt_dp.sv
rtl/gdt_ctrl.sv
rtl/graph_adjacency_degree_tracker.sv
rtl/gdt_chk.sv
tb/graph_adjacency_degree_tracker_test.sv
